[sv/fdtx_pkg.sv]
// Shared types, constants and codes for the MAC transmit pause control block.
`default_nettype none
package fdtx_pkg;

  // Queue and timer dimensions.
  localparam int QUEUE_DEPTH        = 64;
  localparam int PAUSE_QUANTUM_BITS = 512;
  localparam int PAUSE_SHIFT        = $clog2(PAUSE_QUANTUM_BITS);
  localparam int WAIT_W             = 7;
  localparam int QUANTA_W           = 16;
  localparam int CNT_W              = QUANTA_W + PAUSE_SHIFT;
  localparam int GAP_W              = 10;
  localparam int BPT_W              = 7;

  // Configuration port dimensions and reset values.
  localparam int CFG_DATA_W         = 32;
  localparam int CFG_ADDR_W         = 4;
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(96);
  localparam logic [BPT_W-1:0] BPT_RESET = BPT_W'(1);

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_LINK_UP       = 2'd0,
    REG_GAP_BIT_TIMES = 2'd1,
    REG_BITS_PER_TICK = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  // Input event codes.
  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DONE    = 2'd1,
    ACT_PAUSE   = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  // Transmitter modes.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TX    = 2'd1,
    MODE_GAP   = 2'd2,
    MODE_PAUSE = 2'd3
  } mode_t;

  typedef struct packed {
    logic             link_up;
    logic [GAP_W-1:0] gap_bit_times;
    logic [BPT_W-1:0] bits_per_tick;
  } cfg_t;

  typedef struct packed {
    action_t             action;
    logic [QUANTA_W-1:0] pause_quanta;
  } item_t;

  typedef struct packed {
    mode_t               mode;
    logic [WAIT_W-1:0]   waiting_count;
    logic [QUANTA_W-1:0] pending_quanta;
    logic [CNT_W-1:0]    countdown;
  } tx_st_t;

  typedef struct packed {
    mode_t             tx_state;
    logic              start_frame;
    logic              frame_refused;
    logic              event_error;
    logic [WAIT_W-1:0] frames_waiting;
  } result_t;

endpackage
`default_nettype wire

[sv/fdtx_if.sv]
// Valid/ready channel interfaces for event items and result items.
`default_nettype none
interface fdtx_in_if;
  import fdtx_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [QUANTA_W-1:0] pause_quanta;

  modport source (output valid, action, pause_quanta, input ready);
  modport sink   (input valid, action, pause_quanta, output ready);
endinterface

interface fdtx_out_if;
  import fdtx_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        tx_state;
  logic              start_frame;
  logic              frame_refused;
  logic              event_error;
  logic [WAIT_W-1:0] frames_waiting;

  modport source (output valid, tx_state, start_frame, frame_refused, event_error,
                  frames_waiting, input ready);
  modport sink   (input valid, tx_state, start_frame, frame_refused, event_error,
                  frames_waiting, output ready);
endinterface
`default_nettype wire

[sv/fdtx_cfg_regs.sv]
// APB-style configuration registers: link state, gap length and tick size.
`default_nettype none
module fdtx_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [fdtx_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [fdtx_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [fdtx_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready,
  output fdtx_pkg::cfg_t                       cfg
);
  import fdtx_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg        = cfg_r;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_up       <= 1'b1;
      cfg_r.gap_bit_times <= GAP_RESET;
      cfg_r.bits_per_tick <= BPT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_LINK_UP:       cfg_r.link_up       <= cfg_pwdata[0];
        REG_GAP_BIT_TIMES: cfg_r.gap_bit_times <= cfg_pwdata[GAP_W-1:0];
        REG_BITS_PER_TICK: cfg_r.bits_per_tick <= cfg_pwdata[BPT_W-1:0];
        REG_UNUSED:        ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      REG_LINK_UP:       cfg_prdata = CFG_DATA_W'(cfg_r.link_up);
      REG_GAP_BIT_TIMES: cfg_prdata = CFG_DATA_W'(cfg_r.gap_bit_times);
      REG_BITS_PER_TICK: cfg_prdata = CFG_DATA_W'(cfg_r.bits_per_tick);
      REG_UNUSED:        cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/fdtx_step.sv]
// Next-state and result logic for one event item of the transmit controller.
`default_nettype none
module fdtx_step (
  input  wire fdtx_pkg::cfg_t   cfg,
  input  wire fdtx_pkg::tx_st_t st,
  input  wire fdtx_pkg::item_t  item,
  output fdtx_pkg::tx_st_t      st_nxt,
  output fdtx_pkg::result_t     res
);
  import fdtx_pkg::*;

  logic [CNT_W-1:0] step_bits;
  logic [CNT_W-1:0] pause_len;
  logic [CNT_W-1:0] pending_len;
  logic             started;
  logic             refused;
  logic             error;
  logic             q_zero;

  assign step_bits   = CNT_W'(cfg.bits_per_tick);
  assign pause_len   = CNT_W'(item.pause_quanta) << PAUSE_SHIFT;
  assign pending_len = CNT_W'(st.pending_quanta) << PAUSE_SHIFT;
  assign q_zero      = (item.pause_quanta == '0);

  always_comb begin
    st_nxt  = st;
    started = 1'b0;
    refused = 1'b0;
    error   = 1'b0;
    case (item.action)
      // Refused if link down or queue full; else starts when idle or joins the queue.
      ACT_ENQUEUE: begin
        if (!cfg.link_up || st.waiting_count >= WAIT_W'(QUEUE_DEPTH)) begin
          refused = 1'b1;
        end else if (st.mode == MODE_IDLE) begin
          started     = 1'b1;
          st_nxt.mode = MODE_TX;
        end else begin
          st_nxt.waiting_count = st.waiting_count + 1'b1;
        end
      end
      // End of frame (error outside TX): apply a stored pause, else wait out the gap.
      ACT_DONE: begin
        if (st.mode != MODE_TX) begin
          error = 1'b1;
        end else if (st.pending_quanta != '0) begin
          st_nxt.countdown      = pending_len;
          st_nxt.mode           = MODE_PAUSE;
          st_nxt.pending_quanta = '0;
        end else begin
          st_nxt.countdown = CNT_W'(cfg.gap_bit_times);
          st_nxt.mode      = MODE_GAP;
        end
      end
      // PAUSE request: start, restart, end, or store for later.
      ACT_PAUSE: begin
        if (st.mode == MODE_IDLE) begin
          if (!q_zero) begin
            st_nxt.countdown = pause_len;
            st_nxt.mode      = MODE_PAUSE;
          end
        end else if (st.mode == MODE_PAUSE) begin
          if (q_zero) begin
            if (st.waiting_count != '0) begin
              st_nxt.waiting_count = st.waiting_count - 1'b1;
              st_nxt.mode          = MODE_TX;
              started              = 1'b1;
            end else begin
              st_nxt.mode = MODE_IDLE;
            end
          end else begin
            st_nxt.countdown = pause_len;
          end
        end else begin
          st_nxt.pending_quanta = item.pause_quanta;
        end
      end
      // Tick: wear down the gap or pause timer, launch on expiry.
      ACT_TICK: begin
        if (st.mode == MODE_GAP || st.mode == MODE_PAUSE) begin
          if (st.countdown <= step_bits) begin
            st_nxt.countdown = '0;
            if (st.waiting_count != '0) begin
              st_nxt.waiting_count = st.waiting_count - 1'b1;
              st_nxt.mode          = MODE_TX;
              started              = 1'b1;
            end else begin
              st_nxt.mode = MODE_IDLE;
            end
          end else begin
            st_nxt.countdown = st.countdown - step_bits;
          end
        end
      end
    endcase
  end

  assign res.tx_state       = st_nxt.mode;
  assign res.start_frame    = started;
  assign res.frame_refused  = refused;
  assign res.event_error    = error;
  assign res.frames_waiting = st_nxt.waiting_count;

endmodule
`default_nettype wire

[sv/full_duplex_mac_tx_pause_control_core.sv]
// Top level of the full-duplex MAC transmit control with PAUSE handling.
// An accepted item goes from the input register to the result register, one
// item per cycle unless out_chan stalls. The registers each hold one item,
// and the state updates as an item moves between them.
// Reset (rst_n low, synchronous): idle, empty queue, no stored pause, timer
// zero; link up, 96-bit gap, one bit time per tick. No clearing pass.
`default_nettype none
module full_duplex_mac_tx_pause_control_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fdtx_in_if.sink                              in_chan,
  fdtx_out_if.source                           out_chan,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [fdtx_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [fdtx_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [fdtx_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import fdtx_pkg::*;

  cfg_t    cfg;
  item_t   in_r;
  logic    in_v_r;
  result_t out_r;
  logic    out_v_r;
  tx_st_t  st_r;
  tx_st_t  st_nxt;
  result_t res;
  logic    advance;
  logic    in_take;

  fdtx_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fdtx_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Pipeline flow: the input register drains into the result register.
  assign advance       = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.action       <= action_t'(in_chan.action);
      in_r.pause_quanta <= in_chan.pause_quanta;
    end
  end

  // Controller state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode           <= MODE_IDLE;
      st_r.waiting_count  <= '0;
      st_r.pending_quanta <= '0;
      st_r.countdown      <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.tx_state       = out_r.tx_state;
  assign out_chan.start_frame    = out_r.start_frame;
  assign out_chan.frame_refused  = out_r.frame_refused;
  assign out_chan.event_error    = out_r.event_error;
  assign out_chan.frames_waiting = out_r.frames_waiting;

`ifndef NO_ASSERTIONS
  // An idle transmitter never has frames left in the queue.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == MODE_IDLE |-> st_r.waiting_count == '0)
    else $error("idle with frames waiting");

  // The queue count never exceeds its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.waiting_count <= WAIT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // A started frame leaves the transmitter in the transmitting state.
  a_start_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.start_frame |-> out_r.tx_state == MODE_TX)
    else $error("frame start outside transmitting state");

  // An item moved out of the input register shows up as a result next cycle.
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("result lost after advance");
`endif

endmodule
`default_nettype wire
